>>> rtl/core/epoch_seconds_calendar_converter_macros.svh
// Assertion macros for the epoch seconds / calendar converter checker.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef EPOCH_SECONDS_CALENDAR_CONVERTER_MACROS_SVH
`define EPOCH_SECONDS_CALENDAR_CONVERTER_MACROS_SVH

// Same-cycle implication, off while in reset.
`define ESCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define ESCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after any cycle with rst_n low.
`define ESCC_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/escc_pkg.sv
// Shared types, constants and calendar helpers for the epoch seconds converter.
// No dependencies; escc_split, escc_fold and the top level import this package.
package escc_pkg;

  localparam int unsigned EPOCH_YEAR     = 1980;
  localparam int unsigned BASE_LEAPS     = (EPOCH_YEAR - 1) / 4;
  localparam int unsigned DAYS_Y1        = 366;
  localparam int unsigned DAYS_Y2        = 366 + 365;
  localparam int unsigned DAYS_Y3        = 366 + 365 * 2;
  localparam int unsigned DAYS_PER_CYCLE = 366 + 365 * 3;
  localparam int unsigned MONTHS         = 12;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned MINS_PER_HOUR  = 60;
  localparam int unsigned HOURS_PER_DAY  = 24;

  // Pipeline depth from input register to output register
  localparam int NSTAGE = 7;

  // Reciprocals for exact division by constants:
  //   floor(x / 60)   = floor(x[31:2] * RCP_S60 / 2^34)   (x 32 bits)
  //   floor(q / 60)   = floor(q[26:2] * RCP_M60 / 2^29)   (q 27 bits)
  //   floor(q / 24)   = floor(q[20:3] * RCP_H24 / 2^20)   (q 21 bits)
  //   floor(d / 1461) = floor(d * RCP_D1461 / 2^27)       (d 16 bits)
  localparam logic [30:0] RCP_S60   = 31'h44444445;
  localparam logic [25:0] RCP_M60   = 26'h2222223;
  localparam logic [18:0] RCP_H24   = 19'd349526;
  localparam logic [16:0] RCP_D1461 = 17'd91868;

  localparam int CFG_AW = 3;

  typedef enum logic {
    CFG_EPOCH_OFFSET = 1'b0,
    CFG_UNMAPPED     = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ACT_SPLIT = 1'b0,
    ACT_FOLD  = 1'b1
  } action_t;

  typedef logic [NSTAGE-1:0] stage_en_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  // Days before month index idx+1 in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      4'd12:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Days before the start of month m (1..13, 13 is the whole year)
  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    d = cum_days(m - 4'd1);
    if (leap && m >= 4'd3) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

>>> rtl/core/escc_if.sv
// Valid/ready channel interfaces for the converter's input and result items.
// Stand-alone; payload widths are fixed by the field definitions.
interface escc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] seconds_in;
  logic [11:0] year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic [4:0]  hour_in;
  logic [5:0]  minute_in;
  logic [5:0]  second_in;

  modport source (
    output valid, action, seconds_in, year_in, month_in, day_in, hour_in,
           minute_in, second_in,
    input  ready
  );
  modport sink (
    input  valid, action, seconds_in, year_in, month_in, day_in, hour_in,
           minute_in, second_in,
    output ready
  );
endinterface

interface escc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] seconds_out;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;

  modport source (
    output valid, seconds_out, year_out, month_out, day_out, hour_out,
           minute_out, second_out,
    input  ready
  );
  modport sink (
    input  valid, seconds_out, year_out, month_out, day_out, hour_out,
           minute_out, second_out,
    output ready
  );
endinterface

>>> rtl/core/escc_split.sv
// Seconds-to-calendar datapath: seven register stages built around four constant divides.
// Depends on escc_pkg; stage enables come from the top-level pipeline control.
module escc_split import escc_pkg::*; (
  input  logic        clk,
  input  stage_en_t   adv,
  input  logic [31:0] seconds_in,
  input  logic [31:0] epoch_offset,
  output cal_t        cal
);

  // stage 1
  logic [31:0] s1_r;
  // stage 2
  logic [60:0] p2_nxt, p2_r;
  logic [31:0] s2_r;
  // stage 3
  logic [26:0] q1;
  logic [31:0] q1x60;
  logic [5:0]  sec3_nxt, sec3_r;
  logic [50:0] p3_nxt, p3_r;
  logic [26:0] q1_3_r;
  // stage 4
  logic [20:0] q2;
  logic [26:0] q2x60;
  logic [5:0]  min4_nxt, min4_r, sec4_r;
  logic [36:0] p4_nxt, p4_r;
  logic [20:0] q2_4_r;
  // stage 5
  logic [15:0] days;
  logic [20:0] daysx24;
  logic [4:0]  hr5_nxt, hr5_r;
  logic [5:0]  min5_r, sec5_r;
  logic [32:0] p5_nxt, p5_r;
  logic [15:0] days5_r;
  // stage 6
  logic [5:0]  cyc;
  logic [10:0] rem;
  logic [11:0] ybase;
  logic [11:0] year6_nxt, year6_r;
  logic [8:0]  doy6_nxt, doy6_r;
  logic [4:0]  hr6_r;
  logic [5:0]  min6_r, sec6_r;
  // stage 7
  logic        leap7;
  logic        hit;
  logic [3:0]  month7;
  logic [4:0]  day7;
  cal_t        cal7_r;

  always_comb begin
    p2_nxt = 61'(s1_r[31:2]) * 61'(RCP_S60);

    q1       = p2_r[60:34];
    q1x60    = 32'(q1) * 32'(SECS_PER_MIN);
    sec3_nxt = 6'(s2_r - q1x60);
    p3_nxt   = 51'(q1[26:2]) * 51'(RCP_M60);

    q2       = p3_r[49:29];
    q2x60    = 27'(q2) * 27'(MINS_PER_HOUR);
    min4_nxt = 6'(q1_3_r - q2x60);
    p4_nxt   = 37'(q2[20:3]) * 37'(RCP_H24);

    days    = p4_r[35:20];
    daysx24 = 21'(days) * 21'(HOURS_PER_DAY);
    hr5_nxt = 5'(q2_4_r - daysx24);
    p5_nxt  = 33'(days) * 33'(RCP_D1461);

    // Split the four-year cycle into whole years and day of year
    cyc   = p5_r[32:27];
    rem   = 11'(days5_r - 16'(cyc) * 16'(DAYS_PER_CYCLE));
    ybase = 12'(EPOCH_YEAR) + 12'({cyc, 2'b00});
    if (rem >= 11'(DAYS_Y3)) begin
      year6_nxt = ybase + 12'd3;
      doy6_nxt  = 9'(rem - 11'(DAYS_Y3));
    end else if (rem >= 11'(DAYS_Y2)) begin
      year6_nxt = ybase + 12'd2;
      doy6_nxt  = 9'(rem - 11'(DAYS_Y2));
    end else if (rem >= 11'(DAYS_Y1)) begin
      year6_nxt = ybase + 12'd1;
      doy6_nxt  = 9'(rem - 11'(DAYS_Y1));
    end else begin
      year6_nxt = ybase;
      doy6_nxt  = 9'(rem);
    end

    // First month whose end lies past the day of year; else December
    leap7  = (year6_r[1:0] == 2'b00);
    month7 = 4'(MONTHS);
    hit    = 1'b0;
    for (int m = 1; m <= MONTHS; m++) begin
      if (!hit && doy6_r < days_before(4'(m + 1), leap7)) begin
        month7 = 4'(m);
        hit    = 1'b1;
      end
    end
    day7 = 5'(doy6_r - days_before(month7, leap7) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_r <= seconds_in + epoch_offset;
    end
    if (adv[1]) begin
      p2_r <= p2_nxt;
      s2_r <= s1_r;
    end
    if (adv[2]) begin
      p3_r   <= p3_nxt;
      q1_3_r <= q1;
      sec3_r <= sec3_nxt;
    end
    if (adv[3]) begin
      p4_r   <= p4_nxt;
      q2_4_r <= q2;
      min4_r <= min4_nxt;
      sec4_r <= sec3_r;
    end
    if (adv[4]) begin
      p5_r    <= p5_nxt;
      days5_r <= days;
      hr5_r   <= hr5_nxt;
      min5_r  <= min4_r;
      sec5_r  <= sec4_r;
    end
    if (adv[5]) begin
      year6_r <= year6_nxt;
      doy6_r  <= doy6_nxt;
      hr6_r   <= hr5_r;
      min6_r  <= min5_r;
      sec6_r  <= sec5_r;
    end
    if (adv[6]) begin
      cal7_r.year   <= year6_r;
      cal7_r.month  <= month7;
      cal7_r.day    <= day7;
      cal7_r.hour   <= hr6_r;
      cal7_r.minute <= min6_r;
      cal7_r.second <= sec6_r;
    end
  end

  assign cal = cal7_r;

endmodule

>>> rtl/core/escc_fold.sv
// Calendar-to-seconds datapath: day count, then scale by 24, 60, 60, less the offset.
// Depends on escc_pkg; stage enables come from the top-level pipeline control.
module escc_fold import escc_pkg::*; (
  input  logic        clk,
  input  stage_en_t   adv,
  input  cal_t        date,
  input  logic [31:0] epoch_offset,
  output logic [31:0] seconds
);

  logic [11:0] yoff;
  logic [11:0] yr_m1;
  logic        leap_in;
  logic [3:0]  mm;
  logic [19:0] ydays_nxt, ydays_r;
  logic [8:0]  mdays_nxt, mdays_r;
  logic [4:0]  day1_r, hr1_r;
  logic [5:0]  min1_r, min2_r;
  logic [5:0]  sec1_r, sec2_r, sec3_r;
  logic [31:0] t2_nxt, t2_r;
  logic [31:0] t3_nxt, t3_r;
  logic [31:0] t4_nxt, t4_r;
  logic [31:0] t5_r, t6_r, t7_r;

  always_comb begin
    yr_m1   = date.year - 12'd1;
    yoff    = date.year - 12'(EPOCH_YEAR);
    leap_in = (date.year[1:0] == 2'b00);
    // Month above December counts the full year
    mm      = (date.month > 4'd13) ? 4'd13 : date.month;

    ydays_nxt = '0;
    if (date.year > 12'(EPOCH_YEAR)) begin
      ydays_nxt = 20'(yoff) * 20'd365 + 20'(yr_m1[11:2]) - 20'(BASE_LEAPS);
    end
    mdays_nxt = '0;
    if (date.month != 4'd0) begin
      mdays_nxt = days_before(mm, leap_in);
    end

    // Day zero wraps through day - 1
    t2_nxt = (32'(ydays_r) + 32'(mdays_r) + 32'(day1_r) - 32'd1) * 32'(HOURS_PER_DAY)
             + 32'(hr1_r);
    t3_nxt = t2_r * 32'(MINS_PER_HOUR) + 32'(min2_r);
    t4_nxt = t3_r * 32'(SECS_PER_MIN) + 32'(sec3_r);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ydays_r <= ydays_nxt;
      mdays_r <= mdays_nxt;
      day1_r  <= date.day;
      hr1_r   <= date.hour;
      min1_r  <= date.minute;
      sec1_r  <= date.second;
    end
    if (adv[1]) begin
      t2_r   <= t2_nxt;
      min2_r <= min1_r;
      sec2_r <= sec1_r;
    end
    if (adv[2]) begin
      t3_r   <= t3_nxt;
      sec3_r <= sec2_r;
    end
    if (adv[3]) begin
      t4_r <= t4_nxt;
    end
    if (adv[4]) begin
      t5_r <= t4_r - epoch_offset;
    end
    if (adv[5]) begin
      t6_r <= t5_r;
    end
    if (adv[6]) begin
      t7_r <= t6_r;
    end
  end

  assign seconds = t7_r;

endmodule

>>> rtl/core/epoch_seconds_calendar_converter.sv
// Top level of the epoch seconds / calendar converter: pipeline control and config.
// Depends on escc_pkg, escc_if, escc_split and escc_fold.
//
//   channel   | direction | handshake         | carries
//   ----------+-----------+-------------------+---------------------------------
//   in_ch     | sink      | valid / ready     | action, seconds or calendar date
//   out_ch    | source    | valid / ready     | seconds or calendar date
//   cfg_*     | slave     | APB, pready tied  | epoch_offset at byte address 0
//
// One item per cycle while out_ch accepts results; a result is valid once its item
// reaches the last stage register. Seven stages, set by the seconds-to-calendar chain:
// offset add, four reciprocal divides, year split and month search.
// Reset clears the stage valid bits and epoch_offset.
// While out_ch stalls, the last stage holds its result and empty earlier stages
// keep filling; in_ch.ready falls only once all seven stages hold items.
module epoch_seconds_calendar_converter import escc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  escc_in_if.sink           in_ch,
  escc_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  stage_en_t   adv;
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] act_r;
  logic [31:0] epoch_offset_r;
  cfg_reg_t    cfg_sel;
  cal_t        date_in;
  cal_t        cal;
  logic [31:0] secs;
  logic        fold_sel;

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ch.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      act_r[0] <= in_ch.action;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (adv[k]) begin
        act_r[k] <= act_r[k-1];
      end
    end
  end

  assign in_ch.ready = adv[0];

  // Configuration register
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_sel == CFG_EPOCH_OFFSET) ? epoch_offset_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_offset_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_sel == CFG_EPOCH_OFFSET) begin
      epoch_offset_r <= cfg_pwdata;
    end
  end

  always_comb begin
    date_in.year   = in_ch.year_in;
    date_in.month  = in_ch.month_in;
    date_in.day    = in_ch.day_in;
    date_in.hour   = in_ch.hour_in;
    date_in.minute = in_ch.minute_in;
    date_in.second = in_ch.second_in;
  end

  escc_split u_split (
    .clk          (clk),
    .adv          (adv),
    .seconds_in   (in_ch.seconds_in),
    .epoch_offset (epoch_offset_r),
    .cal          (cal)
  );

  escc_fold u_fold (
    .clk          (clk),
    .adv          (adv),
    .date         (date_in),
    .epoch_offset (epoch_offset_r),
    .seconds      (secs)
  );

  // Zero the fields the selected direction does not produce
  assign fold_sel           = (act_r[NSTAGE-1] == ACT_FOLD);
  assign out_ch.valid       = vld_r[NSTAGE-1];
  assign out_ch.seconds_out = fold_sel ? secs : 32'd0;
  assign out_ch.year_out    = fold_sel ? 12'd0 : cal.year;
  assign out_ch.month_out   = fold_sel ? 4'd0 : cal.month;
  assign out_ch.day_out     = fold_sel ? 5'd0 : cal.day;
  assign out_ch.hour_out    = fold_sel ? 5'd0 : cal.hour;
  assign out_ch.minute_out  = fold_sel ? 6'd0 : cal.minute;
  assign out_ch.second_out  = fold_sel ? 6'd0 : cal.second;

endmodule

>>> rtl/core/escc_checker.sv
// Port-level checks for the epoch seconds / calendar converter, bound to the top.
// Depends on escc_if and the macros header.
`include "epoch_seconds_calendar_converter_macros.svh"

module escc_checker (
  input logic        clk,
  input logic        rst_n,
  escc_in_if.sink    in_ch,
  escc_out_if.source out_ch
);

  `ESCC_ASSERT_AFTER_RESET(a_no_result_after_reset, !out_ch.valid, "result valid after reset")

  `ESCC_ASSERT_NEXT(a_stall_holds, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.seconds_out) && $stable(out_ch.year_out) && $stable(out_ch.day_out), "stalled result changed")

  `ESCC_ASSERT_SAME(a_ready_when_empty, !out_ch.valid, in_ch.ready, "input stalled with output stage empty")

  `ESCC_ASSERT_SAME(a_one_direction, out_ch.valid, out_ch.seconds_out == 32'd0 || (out_ch.year_out == 12'd0 && out_ch.month_out == 4'd0 && out_ch.day_out == 5'd0 && out_ch.hour_out == 5'd0 && out_ch.minute_out == 6'd0 && out_ch.second_out == 6'd0), "result carries both seconds and calendar")

  `ESCC_ASSERT_SAME(a_calendar_range, out_ch.valid && out_ch.year_out != 12'd0, out_ch.hour_out < 5'd24 && out_ch.minute_out < 6'd60 && out_ch.second_out < 6'd60 && out_ch.month_out >= 4'd1 && out_ch.month_out <= 4'd12 && out_ch.day_out != 5'd0, "calendar field out of range")

endmodule

bind epoch_seconds_calendar_converter escc_checker u_escc_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
